FILE: src/ppit_pkg.sv
// shared constants and types of the polygon point-inside test unit
// no dependencies
package ppit_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int AUG_W  = COORD_BITS + 2;
    localparam int NUM_W  = 2 * DIFF_W;
    localparam int MUL_W  = AUG_W + DIFF_W;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_VERTICES);

    localparam logic signed [COORD_BITS-1:0] COORD_TOP = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_BOT = {1'b1, {(COORD_BITS-1){1'b0}}};

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_TEST   = 2'd3;

    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] x2;
        logic signed [COORD_BITS-1:0] y2;
    } edge_t;

endpackage

FILE: src/polygon_point_inside_test_unit.sv
// polygon point-inside test unit, top level
// depends on ppit_pkg, ppit_cell, ppit_edge_unit
//
// an item is taken at a clock edge with start high and busy low.
// kind selects add vertex, remove last vertex, clear, or test point.
// each item gives one result, shown for one cycle with done high:
// inside_res, count, the bounding box and fault.
// add, clear and a faulting remove finish without leaving idle; done
// follows on the next cycle and busy stays low, so these items may
// follow back to back.
// test and a good remove rotate the vertex chain once, one vertex per
// cycle, in the walk state, then drain the two-stage multiply pipe
// of the edge unit in the drain state; done comes after the drain.
// busy is high for the walk and the drain.
// reset empties the table and the box; vertex contents are not cleared.
// results cannot be held off; they must be taken in the done cycle.
module polygon_point_inside_test_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [1:0]                             kind,
    input  logic signed [ppit_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [ppit_pkg::COORD_BITS-1:0] coord_y,
    output logic                                   busy,
    output logic                                   done,
    output logic                                   inside_res,
    output logic [6:0]                             count,
    output logic signed [ppit_pkg::COORD_BITS-1:0] box_min_x,
    output logic signed [ppit_pkg::COORD_BITS-1:0] box_min_y,
    output logic signed [ppit_pkg::COORD_BITS-1:0] box_max_x,
    output logic signed [ppit_pkg::COORD_BITS-1:0] box_max_y,
    output logic                                   fault
);

    localparam int CB  = ppit_pkg::COORD_BITS;
    localparam int NV  = ppit_pkg::MAX_VERTICES;
    localparam int CW  = ppit_pkg::CNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] step_reg, step_next;
    logic [1:0]    drain_reg, drain_next;
    logic          is_test_reg, is_test_next;
    logic          done_reg, done_next;
    logic          inside_reg, inside_next;
    logic          fault_reg, fault_next;
    logic signed [CB-1:0] lo_x_reg, lo_x_next, lo_y_reg, lo_y_next;
    logic signed [CB-1:0] hi_x_reg, hi_x_next, hi_y_reg, hi_y_next;
    logic signed [CB-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [CB-1:0] prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;

    logic signed [CB-1:0] cx [NV];
    logic signed [CB-1:0] cy [NV];
    logic                 shift, take, add_ok;
    logic signed [CB-1:0] head_x, head_y;
    ppit_pkg::edge_t      edge_sel;
    logic                 toggle;

    assign take   = start && !busy;
    assign add_ok = take && (kind == ppit_pkg::KIND_ADD) && (cnt_reg < ppit_pkg::MAX_COUNT);
    assign shift  = (state_reg == S_WALK) && (step_reg < ppit_pkg::MAX_COUNT);
    assign head_x = cx[0];
    assign head_y = cy[0];

    genvar k;
    generate
        for (k = 0; k < NV; k++)
        begin : g_cell
            ppit_cell u_cell
            (
                .clk   (clk),
                .shift (shift),
                .wr    (add_ok && (cnt_reg == CW'(k))),
                .wr_x  (coord_x),
                .wr_y  (coord_y),
                .nb_x  (cx[(k + 1) % NV]),
                .nb_y  (cy[(k + 1) % NV]),
                .x     (cx[k]),
                .y     (cy[k])
            );
        end
    endgenerate

    // edge i pairs vertex i with i-1; the closing edge pairs vertex 0 with the last
    always_comb
    begin
        edge_sel.valid = (state_reg == S_WALK) && is_test_reg
                      && (((step_reg != '0) && (step_reg < cnt_reg))
                       || ((step_reg == cnt_reg) && (cnt_reg != '0)));
        edge_sel.x1 = (step_reg == cnt_reg) ? first_x_reg : head_x;
        edge_sel.y1 = (step_reg == cnt_reg) ? first_y_reg : head_y;
        edge_sel.x2 = prev_x_reg;
        edge_sel.y2 = prev_y_reg;
    end

    ppit_edge_unit u_edge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .edge_in (edge_sel),
        .px      (px_reg),
        .py      (py_reg),
        .toggle  (toggle)
    );

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        step_next    = step_reg;
        drain_next   = drain_reg;
        is_test_next = is_test_reg;
        done_next    = 1'b0;
        inside_next  = inside_reg ^ toggle;
        fault_next   = fault_reg;
        lo_x_next    = lo_x_reg;
        lo_y_next    = lo_y_reg;
        hi_x_next    = hi_x_reg;
        hi_y_next    = hi_y_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    inside_next = 1'b0;
                    fault_next  = 1'b0;
                    case (kind)
                        ppit_pkg::KIND_ADD:
                        begin
                            done_next = 1'b1;
                            if (add_ok)
                            begin
                                cnt_next = cnt_reg + CW'(1);
                                if (coord_x < lo_x_reg) lo_x_next = coord_x;
                                if (coord_y < lo_y_reg) lo_y_next = coord_y;
                                if (coord_x > hi_x_reg) hi_x_next = coord_x;
                                if (coord_y > hi_y_reg) hi_y_next = coord_y;
                            end
                            else
                                fault_next = 1'b1;
                        end
                        ppit_pkg::KIND_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fault_next = 1'b1;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                cnt_next     = cnt_reg - CW'(1);
                                lo_x_next    = ppit_pkg::COORD_TOP;
                                lo_y_next    = ppit_pkg::COORD_TOP;
                                hi_x_next    = ppit_pkg::COORD_BOT;
                                hi_y_next    = ppit_pkg::COORD_BOT;
                                is_test_next = 1'b0;
                                step_next    = '0;
                                state_next   = S_WALK;
                            end
                        end
                        ppit_pkg::KIND_CLEAR:
                        begin
                            cnt_next  = '0;
                            lo_x_next = ppit_pkg::COORD_TOP;
                            lo_y_next = ppit_pkg::COORD_TOP;
                            hi_x_next = ppit_pkg::COORD_BOT;
                            hi_y_next = ppit_pkg::COORD_BOT;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            px_next      = coord_x;
                            py_next      = coord_y;
                            is_test_next = 1'b1;
                            step_next    = '0;
                            state_next   = S_WALK;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (!is_test_reg && (step_reg < cnt_reg))
                begin
                    if (head_x < lo_x_reg) lo_x_next = head_x;
                    if (head_y < lo_y_reg) lo_y_next = head_y;
                    if (head_x > hi_x_reg) hi_x_next = head_x;
                    if (head_y > hi_y_reg) hi_y_next = head_y;
                end
                if (step_reg == ppit_pkg::MAX_COUNT)
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
                else
                    step_next = step_reg + CW'(1);
            end
            S_DRAIN:
            begin
                if (drain_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    drain_next = drain_reg + 2'd1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            step_reg    <= '0;
            drain_reg   <= '0;
            is_test_reg <= 1'b0;
            done_reg    <= 1'b0;
            inside_reg  <= 1'b0;
            fault_reg   <= 1'b0;
            lo_x_reg    <= ppit_pkg::COORD_TOP;
            lo_y_reg    <= ppit_pkg::COORD_TOP;
            hi_x_reg    <= ppit_pkg::COORD_BOT;
            hi_y_reg    <= ppit_pkg::COORD_BOT;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            drain_reg   <= drain_next;
            is_test_reg <= is_test_next;
            done_reg    <= done_next;
            inside_reg  <= inside_next;
            fault_reg   <= fault_next;
            lo_x_reg    <= lo_x_next;
            lo_y_reg    <= lo_y_next;
            hi_x_reg    <= hi_x_next;
            hi_y_reg    <= hi_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        prev_x_reg <= head_x;
        prev_y_reg <= head_y;
        if ((state_reg == S_WALK) && (step_reg == '0))
        begin
            first_x_reg <= head_x;
            first_y_reg <= head_y;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign count      = 7'(cnt_reg);
    assign box_min_x  = lo_x_reg;
    assign box_min_y  = lo_y_reg;
    assign box_max_x  = hi_x_reg;
    assign box_max_y  = hi_y_reg;
    assign fault      = fault_reg;

    a_no_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !done_reg)
        else $error("result strobe during vertex walk");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ppit_pkg::MAX_COUNT)
        else $error("vertex count above table size");

    a_fault_no_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && fault_reg) |-> !inside_reg)
        else $error("inside flag on a faulting item");

    a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (cnt_reg == '0)) |->
            ((lo_x_reg == ppit_pkg::COORD_TOP) && (hi_y_reg == ppit_pkg::COORD_BOT)))
        else $error("box not empty with empty table");

endmodule

FILE: src/ppit_cell.sv
// one vertex cell of the rotating vertex chain
// depends on ppit_pkg
module ppit_cell
(
    input  logic                                  clk,
    input  logic                                  shift,
    input  logic                                  wr,
    input  logic signed [ppit_pkg::COORD_BITS-1:0] wr_x,
    input  logic signed [ppit_pkg::COORD_BITS-1:0] wr_y,
    input  logic signed [ppit_pkg::COORD_BITS-1:0] nb_x,
    input  logic signed [ppit_pkg::COORD_BITS-1:0] nb_y,
    output logic signed [ppit_pkg::COORD_BITS-1:0] x,
    output logic signed [ppit_pkg::COORD_BITS-1:0] y
);

    logic signed [ppit_pkg::COORD_BITS-1:0] x_reg;
    logic signed [ppit_pkg::COORD_BITS-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            x_reg <= wr_x;
            y_reg <= wr_y;
        end
        else if (shift)
        begin
            x_reg <= nb_x;
            y_reg <= nb_y;
        end
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

FILE: src/ppit_edge_unit.sv
// crossing test of one edge per cycle, two register stages
// crossing compare is done by cross multiplication, no divider
// depends on ppit_pkg
module ppit_edge_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ppit_pkg::edge_t                        edge_in,
    input  logic signed [ppit_pkg::COORD_BITS-1:0] px,
    input  logic signed [ppit_pkg::COORD_BITS-1:0] py,
    output logic                                   toggle
);

    localparam int CB = ppit_pkg::COORD_BITS;
    localparam int DW = ppit_pkg::DIFF_W;
    localparam int AW = ppit_pkg::AUG_W;
    localparam int NW = ppit_pkg::NUM_W;
    localparam int MW = ppit_pkg::MUL_W;

    logic signed [DW-1:0] dx, dyp, dd, aa_raw;
    logic signed [AW-1:0] aa;
    logic                 spans, neg;

    logic                 a_valid_reg;
    logic signed [DW-1:0] dx_reg, dyp_reg, d_reg;
    logic signed [AW-1:0] aa_reg;
    logic                 a_neg_reg;

    logic                 b_valid_reg;
    logic signed [NW-1:0] n_reg;
    logic signed [MW-1:0] m_reg;
    logic                 b_neg_reg, b_dpos_reg;

    logic signed [MW-1:0] n_ext;

    always_comb
    begin
        dx     = $signed({edge_in.x2[CB-1], edge_in.x2}) - $signed({edge_in.x1[CB-1], edge_in.x1});
        dyp    = $signed({py[CB-1], py}) - $signed({edge_in.y1[CB-1], edge_in.y1});
        dd     = $signed({edge_in.y2[CB-1], edge_in.y2}) - $signed({edge_in.y1[CB-1], edge_in.y1});
        aa_raw = $signed({px[CB-1], px}) - $signed({edge_in.x1[CB-1], edge_in.x1});
        spans  = ((edge_in.y1 <= py) && (py < edge_in.y2))
              || ((edge_in.y2 <= py) && (py < edge_in.y1));
        // quotient negative: truncation rounds up instead of down
        neg    = (dx != '0) && (dyp != '0) && ((dx[DW-1] ^ dyp[DW-1]) != dd[DW-1]);
        aa     = neg ? $signed({aa_raw[DW-1], aa_raw})
                     : $signed({aa_raw[DW-1], aa_raw}) + AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= edge_in.valid && spans;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx;
        dyp_reg    <= dyp;
        d_reg      <= dd;
        aa_reg     <= aa;
        a_neg_reg  <= neg;
        n_reg      <= dx_reg * dyp_reg;
        m_reg      <= aa_reg * d_reg;
        b_neg_reg  <= a_neg_reg;
        b_dpos_reg <= !d_reg[DW-1];
    end

    assign n_ext = MW'(n_reg);

    always_comb
    begin
        if (b_neg_reg)
            toggle = b_valid_reg && (b_dpos_reg ? (m_reg < n_ext) : (m_reg > n_ext));
        else
            toggle = b_valid_reg && (b_dpos_reg ? (m_reg <= n_ext) : (m_reg >= n_ext));
    end

endmodule

FILE: verif/polygon_point_inside_test_unit_tb.sv
// testbench of polygon_point_inside_test_unit: directed and random items,
// with results checked against a vertex table and box model kept here
// depends on ppit_pkg and the polygon_point_inside_test_unit rtl
module polygon_point_inside_test_unit_tb;

    typedef logic signed [ppit_pkg::COORD_BITS-1:0] coord_t;

    typedef struct {
        logic       inside_res;
        logic [6:0] count;
        coord_t     min_x;
        coord_t     min_y;
        coord_t     max_x;
        coord_t     max_y;
        logic       fault;
    } poly_result_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic [1:0] kind;
    coord_t     coord_x;
    coord_t     coord_y;
    logic       busy;
    logic       done;
    logic       inside_res;
    logic [6:0] count;
    coord_t     box_min_x;
    coord_t     box_min_y;
    coord_t     box_max_x;
    coord_t     box_max_y;
    logic       fault;

    polygon_point_inside_test_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .busy       (busy),
        .done       (done),
        .inside_res (inside_res),
        .count      (count),
        .box_min_x  (box_min_x),
        .box_min_y  (box_min_y),
        .box_max_x  (box_max_x),
        .box_max_y  (box_max_y),
        .fault      (fault)
    );

    // model of the vertex table and box
    coord_t tbl_x [ppit_pkg::MAX_VERTICES];
    coord_t tbl_y [ppit_pkg::MAX_VERTICES];
    int     tbl_n;
    coord_t lo_x, lo_y, hi_x, hi_y;

    poly_result_t pending_results[$];
    int errors;
    int items_sent;
    int idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 2000000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void box_reset();
        lo_x = ppit_pkg::COORD_TOP;
        lo_y = ppit_pkg::COORD_TOP;
        hi_x = ppit_pkg::COORD_BOT;
        hi_y = ppit_pkg::COORD_BOT;
    endfunction

    function automatic void box_grow(coord_t x, coord_t y);
        if (x < lo_x) lo_x = x;
        if (y < lo_y) lo_y = y;
        if (x > hi_x) hi_x = x;
        if (y > hi_y) hi_y = y;
    endfunction

    function automatic logic crossing_parity(coord_t px, coord_t py);
        logic   in_flag;
        int     j;
        longint x1, y1, x2, y2, xc;
        in_flag = 1'b0;
        if (tbl_n == 0)
            return 1'b0;
        j = tbl_n - 1;
        for (int i = 0; i < tbl_n; i++)
        begin
            x1 = tbl_x[i];
            y1 = tbl_y[i];
            x2 = tbl_x[j];
            y2 = tbl_y[j];
            if (((y1 <= py) && (py < y2)) || ((y2 <= py) && (py < y1)))
            begin
                xc = (x2 - x1) * (py - y1) / (y2 - y1) + x1;
                if (px < xc)
                    in_flag = ~in_flag;
            end
            j = i;
        end
        return in_flag;
    endfunction

    function automatic poly_result_t predict_item(logic [1:0] k, coord_t x, coord_t y);
        poly_result_t r;
        r.inside_res = 1'b0;
        r.fault      = 1'b0;
        case (k)
            ppit_pkg::KIND_ADD:
                if (tbl_n >= ppit_pkg::MAX_VERTICES)
                    r.fault = 1'b1;
                else
                begin
                    tbl_x[tbl_n] = x;
                    tbl_y[tbl_n] = y;
                    tbl_n++;
                    box_grow(x, y);
                end
            ppit_pkg::KIND_REMOVE:
                if (tbl_n == 0)
                    r.fault = 1'b1;
                else
                begin
                    tbl_n--;
                    box_reset();
                    for (int i = 0; i < tbl_n; i++)
                        box_grow(tbl_x[i], tbl_y[i]);
                end
            ppit_pkg::KIND_CLEAR:
            begin
                tbl_n = 0;
                box_reset();
            end
            default:
                r.inside_res = crossing_parity(x, y);
        endcase
        r.count = 7'(tbl_n);
        r.min_x = lo_x;
        r.min_y = lo_y;
        r.max_x = hi_x;
        r.max_y = hi_y;
        return r;
    endfunction

    // start stays high across back to back items; it is lowered only for a gap
    task automatic send_item(logic [1:0] k, coord_t x, coord_t y);
        logic busy_seen;
        int   gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        kind    <= k;
        coord_x <= x;
        coord_y <= y;
        do
        begin
            @(negedge clk);
            busy_seen = busy;
            @(posedge clk);
        end
        while (busy_seen);
        pending_results.insert(pending_results.size(), predict_item(k, x, y));
        items_sent++;
    endtask

    // results are stable mid-cycle; done lasts exactly one cycle
    always @(negedge clk)
    begin
        poly_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: count=%0d", count);
            end
            else
            begin
                e = pending_results.pop_front();
                if (inside_res !== e.inside_res || count !== e.count
                    || box_min_x !== e.min_x || box_min_y !== e.min_y
                    || box_max_x !== e.max_x || box_max_y !== e.max_y
                    || fault !== e.fault)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: exp in=%0b n=%0d box=(%0d,%0d)-(%0d,%0d) f=%0b",
                            e.inside_res, e.count, e.min_x, e.min_y, e.max_x, e.max_y,
                            e.fault);
                        $display("          got in=%0b n=%0d box=(%0d,%0d)-(%0d,%0d) f=%0b",
                            inside_res, count, box_min_x, box_min_y,
                            box_max_x, box_max_y, fault);
                    end
                end
            end
        end
    end

    function automatic coord_t rand_coord(bit wide);
        if (wide)
            return coord_t'($urandom_range(65535));
        return coord_t'($urandom_range(400) - 200);
    endfunction

    function automatic coord_t rand_between(coord_t lo, coord_t hi);
        int a, b;
        a = lo;
        b = hi;
        if (b < a)
            return coord_t'(a);
        return coord_t'(a + $urandom_range(b - a));
    endfunction

    task automatic test_directed();
        // test on empty table
        send_item(ppit_pkg::KIND_TEST, ppit_pkg::COORD_BOT, ppit_pkg::COORD_TOP);
        send_item(ppit_pkg::KIND_REMOVE, 16'sd0, 16'sd0);        // remove on empty
        send_item(ppit_pkg::KIND_ADD, ppit_pkg::COORD_BOT, ppit_pkg::COORD_BOT);
        // single vertex
        send_item(ppit_pkg::KIND_TEST, ppit_pkg::COORD_BOT, ppit_pkg::COORD_BOT);
        send_item(ppit_pkg::KIND_ADD, ppit_pkg::COORD_TOP, ppit_pkg::COORD_TOP);
        send_item(ppit_pkg::KIND_TEST, 16'sd0, 16'sd0);          // two vertices
        send_item(ppit_pkg::KIND_ADD, ppit_pkg::COORD_TOP, ppit_pkg::COORD_BOT);
        send_item(ppit_pkg::KIND_TEST, 16'sd100, 16'sd0);
        send_item(ppit_pkg::KIND_TEST, ppit_pkg::COORD_BOT, 16'sd0);
        send_item(ppit_pkg::KIND_TEST, ppit_pkg::COORD_TOP, ppit_pkg::COORD_TOP);
        send_item(ppit_pkg::KIND_TEST, 16'sd32000, -16'sd32000);
        send_item(ppit_pkg::KIND_REMOVE, 16'sd0, 16'sd0);
        send_item(ppit_pkg::KIND_CLEAR, 16'sd0, 16'sd0);
        // square with two horizontal edges
        send_item(ppit_pkg::KIND_ADD, -16'sd10, -16'sd10);
        send_item(ppit_pkg::KIND_ADD, 16'sd10, -16'sd10);
        send_item(ppit_pkg::KIND_ADD, 16'sd10, 16'sd10);
        send_item(ppit_pkg::KIND_ADD, -16'sd10, 16'sd10);
        send_item(ppit_pkg::KIND_TEST, 16'sd0, 16'sd0);
        send_item(ppit_pkg::KIND_TEST, 16'sd0, -16'sd10);
        send_item(ppit_pkg::KIND_TEST, 16'sd0, 16'sd10);
        send_item(ppit_pkg::KIND_TEST, -16'sd10, 16'sd0);
        send_item(ppit_pkg::KIND_TEST, 16'sd10, 16'sd0);
        send_item(ppit_pkg::KIND_TEST, 16'sd20, 16'sd0);
        send_item(ppit_pkg::KIND_CLEAR, 16'sd0, 16'sd0);
    endtask

    task automatic test_full_table();
        send_item(ppit_pkg::KIND_CLEAR, 16'sd0, 16'sd0);
        for (int i = 0; i < ppit_pkg::MAX_VERTICES; i++)
            send_item(ppit_pkg::KIND_ADD, rand_coord(1), rand_coord(1));
        send_item(ppit_pkg::KIND_ADD, 16'sd1, 16'sd1);           // add on full table
        for (int i = 0; i < 4; i++)
            send_item(ppit_pkg::KIND_TEST, rand_coord(1), rand_coord(1));
        while (tbl_n > 0)
        begin
            if ($urandom_range(9) == 0)
                send_item(ppit_pkg::KIND_TEST, rand_coord(1), rand_coord(1));
            send_item(ppit_pkg::KIND_REMOVE, rand_coord(1), rand_coord(1));
        end
        send_item(ppit_pkg::KIND_REMOVE, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_polygons(int target);
        int     nv, nt, sel;
        bit     wide;
        coord_t px, py;
        while (items_sent < target)
        begin
            if (items_sent < target / 3)
                idle_pct = 12;
            else if (items_sent < 2 * target / 3)
                idle_pct = 88;
            else
                idle_pct = 0;
            send_item(ppit_pkg::KIND_CLEAR, rand_coord(1), rand_coord(1));
            wide = $urandom_range(1);
            sel  = $urandom_range(19);
            nv   = (sel == 0) ? $urandom_range(1, 2)
                 : (sel == 1) ? $urandom_range(20, ppit_pkg::MAX_VERTICES)
                 : $urandom_range(3, 9);
            for (int i = 0; i < nv; i++)
                send_item(ppit_pkg::KIND_ADD, rand_coord(wide), rand_coord(wide));
            nt = $urandom_range(2, 8);
            for (int t = 0; t < nt; t++)
            begin
                sel = $urandom_range(9);
                if (sel < 6)
                begin
                    px = rand_between(lo_x, hi_x);
                    py = rand_between(lo_y, hi_y);
                end
                else if (sel < 8 && tbl_n > 0)
                begin
                    // hit a vertex row exactly
                    px = rand_between(lo_x, hi_x);
                    py = tbl_y[$urandom_range(tbl_n - 1)];
                end
                else
                begin
                    px = rand_coord(1);
                    py = rand_coord(1);
                end
                send_item(ppit_pkg::KIND_TEST, px, py);
                sel = $urandom_range(19);
                if (sel == 0)
                    send_item(ppit_pkg::KIND_REMOVE, rand_coord(1), rand_coord(1));
                else if (sel == 1)
                    send_item(ppit_pkg::KIND_ADD, rand_coord(wide), rand_coord(wide));
                else if (sel == 2)
                    send_item(2'($urandom_range(3)), rand_coord(1), rand_coord(1));
            end
        end
    endtask

    initial
    begin
        int waited;
        start      = 1'b0;
        kind       = ppit_pkg::KIND_ADD;
        coord_x    = '0;
        coord_y    = '0;
        rst_n      = 1'b0;
        errors     = 0;
        items_sent = 0;
        idle_pct   = 12;
        tbl_n      = 0;
        box_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random_polygons(1050);
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0d results never arrived", pending_results.size());
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
src/ppit_pkg.sv
src/ppit_cell.sv
src/ppit_edge_unit.sv
src/polygon_point_inside_test_unit.sv
verif/polygon_point_inside_test_unit_tb.sv
